// File: hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/bsc_pkg.sv
// package: types, command codes and helpers for the box/sphere clip block
package bsc_pkg;

    localparam int COORD_BITS = 32;
    localparam int DIMS       = 3;
    localparam int CMD_BITS   = 3;
    localparam int FLAG_BITS  = 2 * DIMS;

    typedef logic [CMD_BITS-1:0] cmd_t;

    localparam cmd_t CMD_RESET     = 3'd0;
    localparam cmd_t CMD_EMPTY     = 3'd1;
    localparam cmd_t CMD_MISS      = 3'd2;
    localparam cmd_t CMD_INTERSECT = 3'd3;
    localparam cmd_t CMD_EXCLUDE   = 3'd4;
    localparam cmd_t CMD_CUBE      = 3'd5;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS-2:0] radius_t;

    localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    typedef struct packed {
        cmd_t    command;
        coord_t  center_x;
        coord_t  center_y;
        coord_t  center_z;
        radius_t radius;
    } req_t;

    typedef struct packed {
        coord_t                lower_x;
        coord_t                upper_x;
        coord_t                lower_y;
        coord_t                upper_y;
        coord_t                lower_z;
        coord_t                upper_z;
        logic [FLAG_BITS-1:0]  moved_flags;
        logic                  box_empty;
        logic                  sphere_misses;
    } rsp_t;

    // c + s or c - s, saturated to the code range
    function automatic coord_t sat_add(input coord_t c, input radius_t s, input logic neg);
        logic [COORD_BITS:0] sum;
        coord_t res;
        if (neg)
            sum = {c[COORD_BITS-1], c} - {2'b00, s};
        else
            sum = {c[COORD_BITS-1], c} + {2'b00, s};
        if (sum[COORD_BITS] != sum[COORD_BITS-1])
            res = sum[COORD_BITS] ? CMIN : CMAX;
        else
            res = sum[COORD_BITS-1:0];
        return res;
    endfunction

    function automatic logic [COORD_BITS-1:0] absdiff(input coord_t a, input coord_t b);
        logic [COORD_BITS-1:0] res;
        if (a >= b)
            res = a - b;
        else
            res = b - a;
        return res;
    endfunction

endpackage

// File: hw/rtl/bsc_mul.sv
// shift-add squaring unit, one operand bit per cycle
module bsc_mul #(
    parameter int W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [W-1:0]   operand,
    output logic           done,
    output logic [2*W-1:0] product
);
    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [2*W-1:0] acc_reg, acc_next;
    logic [2*W-1:0] mcand_reg, mcand_next;
    logic [W-1:0]   mplier_reg, mplier_next;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = CW'(W - 1);
            acc_next    = '0;
            mcand_next  = {{W{1'b0}}, operand};
            mplier_next = operand;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

// File: hw/rtl/bsc_sqrt.sv
// digit-by-digit floor square root, one root bit per cycle
module bsc_sqrt #(
    parameter int RW = 62
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [RW-1:0]   radicand,
    output logic            done,
    output logic [RW/2-1:0] root
);
    localparam int QW = RW / 2;
    localparam int CW = (QW > 1) ? $clog2(QW) : 1;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0] x_reg, x_next;
    logic [QW+1:0] rem_reg, rem_next;
    logic [QW-1:0] root_reg, root_next;
    logic [QW+1:0] rem_sh;
    logic [QW+1:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        rem_sh    = {rem_reg[QW-1:0], x_reg[RW-1:RW-2]};
        trial     = {root_reg, 2'b01};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(QW - 1);
            x_next    = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            x_next = x_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// File: hw/rtl/box_sphere_clip_3d.sv
// top level: box state, command sequencer, shared square and root units
//
//   port    | dir | handshake              | item
//   req     | in  | req_valid / req_stall  | command, sphere center, radius
//   rsp     | out | rsp_valid / rsp_stall  | bounds, moved flags, empty, miss
//
// reset, make empty, bounding cube and unused codes go from the prep state straight to the done state
// miss test runs four squares on the shift-add unit
// intersect and exclude add up to three roots after the four squares
// req_stall is high from acceptance until the result is written to the output register
// a result held by rsp_stall blocks only the finish of the next item
`include "assert_macros.svh"
module box_sphere_clip_3d (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bsc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bsc_pkg::rsp_t rsp
);
    import bsc_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int SQW = 2 * C;
    localparam int TW  = SQW + 2;
    localparam int BW  = SQW + 3;
    localparam int RW  = SQW - 2;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_PREP  = 8'b00000010,
        ST_SQ    = 8'b00000100,
        ST_BASE  = 8'b00001000,
        ST_AXIS  = 8'b00010000,
        ST_ROOT  = 8'b00100000,
        ST_APPLY = 8'b01000000,
        ST_DONE  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic [1:0] j_reg, j_next;
    logic [1:0] k_reg, k_next;
    logic   miss_reg, miss_next;
    logic [FLAG_BITS-1:0] moved_reg, moved_next;
    coord_t lo_reg[DIMS], lo_next[DIMS];
    coord_t up_reg[DIMS], up_next[DIMS];

    coord_t  c_reg[DIMS], c_next[DIMS];
    radius_t r_reg, r_next;
    coord_t  pt_reg[DIMS], pt_next[DIMS];
    logic [C-1:0]   diff_reg[DIMS], diff_next[DIMS];
    logic [SQW-1:0] sq_reg[DIMS], sq_next[DIMS];
    logic [SQW-1:0] r2_reg, r2_next;
    logic [TW-1:0]  total_reg, total_next;
    logic [BW-1:0]  base_reg, base_next;
    radius_t s_reg[DIMS], s_next[DIMS];

    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;

    logic         mul_start, mul_done;
    logic [C-1:0] mul_operand;
    logic [SQW-1:0] mul_product;
    logic         sqrt_start, sqrt_done;
    logic [RW-1:0] sqrt_radicand;
    radius_t      sqrt_root;

    coord_t pick_w[DIMS];
    coord_t near_w[DIMS];
    coord_t far_w[DIMS];
    logic [BW-1:0] base_w;
    logic [BW-1:0] d_w;
    logic   d_pos;
    coord_t lo_w, hi_w, u1_w;
    logic   empty_w;
    logic   rsp_load;

    bsc_mul #(.W(C)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (mul_operand),
        .done    (mul_done),
        .product (mul_product)
    );

    bsc_sqrt #(.RW(RW)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_radicand),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // nearest box point or far corner per axis
    always_comb
    begin
        for (int k = 0; k < DIMS; k++)
        begin
            near_w[k] = c_reg[k];
            if (near_w[k] <= lo_reg[k])
                near_w[k] = lo_reg[k];
            if (near_w[k] >= up_reg[k])
                near_w[k] = up_reg[k];
            far_w[k] = (absdiff(c_reg[k], up_reg[k]) >= absdiff(c_reg[k], lo_reg[k]))
                       ? up_reg[k] : lo_reg[k];
            pick_w[k] = (cmd_reg == CMD_EXCLUDE) ? far_w[k] : near_w[k];
        end
    end

    assign base_w        = {3'b000, r2_reg} - {1'b0, total_reg};
    assign d_w           = base_reg + {3'b000, sq_reg[k_reg]};
    assign d_pos         = !d_w[BW-1] && (d_w != '0);
    assign sqrt_radicand = d_w[RW-1:0];
    assign lo_w          = sat_add(c_reg[k_reg], s_reg[k_reg], 1'b1);
    assign hi_w          = sat_add(c_reg[k_reg], s_reg[k_reg], 1'b0);
    assign mul_operand   = (state_reg == ST_PREP) ? {1'b0, r_reg} : diff_reg[j_reg];

    always_comb
    begin
        empty_w = 1'b0;
        for (int k = 0; k < DIMS; k++)
            if (lo_reg[k] >= up_reg[k])
                empty_w = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        miss_next  = miss_reg;
        moved_next = moved_reg;
        lo_next    = lo_reg;
        up_next    = up_reg;
        c_next     = c_reg;
        r_next     = r_reg;
        pt_next    = pt_reg;
        diff_next  = diff_reg;
        sq_next    = sq_reg;
        r2_next    = r2_reg;
        total_next = total_reg;
        base_next  = base_reg;
        s_next     = s_reg;
        mul_start  = 1'b0;
        sqrt_start = 1'b0;
        rsp_load   = 1'b0;
        u1_w       = up_reg[k_reg];

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = req.command;
                    c_next[0]  = req.center_x;
                    c_next[1]  = req.center_y;
                    c_next[2]  = req.center_z;
                    r_next     = req.radius;
                    miss_next  = 1'b0;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                for (int k = 0; k < DIMS; k++)
                begin
                    pt_next[k]   = pick_w[k];
                    diff_next[k] = absdiff(c_reg[k], pick_w[k]);
                end
                j_next     = 2'd0;
                k_next     = 2'd0;
                total_next = '0;
                state_next = ST_DONE;
                case (cmd_reg)
                    CMD_RESET:
                    begin
                        for (int k = 0; k < DIMS; k++)
                        begin
                            lo_next[k] = CMIN;
                            up_next[k] = CMAX;
                        end
                        moved_next = '0;
                    end
                    CMD_EMPTY:
                    begin
                        for (int k = 0; k < DIMS; k++)
                        begin
                            lo_next[k] = '0;
                            up_next[k] = '0;
                        end
                    end
                    CMD_MISS, CMD_INTERSECT, CMD_EXCLUDE:
                    begin
                        mul_start  = 1'b1;
                        state_next = ST_SQ;
                        if (cmd_reg == CMD_EXCLUDE)
                            moved_next = '0;
                    end
                    CMD_CUBE:
                    begin
                        for (int k = 0; k < DIMS; k++)
                        begin
                            lo_next[k] = sat_add(c_reg[k], r_reg, 1'b1);
                            up_next[k] = sat_add(c_reg[k], r_reg, 1'b0);
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SQ:
            begin
                if (mul_done)
                begin
                    if (j_reg == 2'd0)
                        r2_next = mul_product;
                    else
                    begin
                        sq_next[j_reg - 2'd1] = mul_product;
                        total_next = total_reg + {2'b00, mul_product};
                    end
                    if (j_reg == 2'd3)
                        state_next = ST_BASE;
                    else
                    begin
                        mul_start = 1'b1;
                        j_next    = j_reg + 2'd1;
                    end
                end
            end
            ST_BASE:
            begin
                base_next = base_w;
                k_next    = 2'd0;
                if (cmd_reg == CMD_MISS)
                begin
                    if (base_w[BW-1] || (base_w == '0))
                    begin
                        miss_next  = 1'b1;
                        moved_next = '0;
                    end
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_AXIS;
            end
            ST_AXIS:
            begin
                if (d_pos)
                begin
                    sqrt_start = 1'b1;
                    state_next = ST_ROOT;
                end
                else if (cmd_reg == CMD_INTERSECT)
                begin
                    lo_next[0] = up_reg[0];
                    moved_next = '0;
                    state_next = ST_DONE;
                end
                else if (k_reg == 2'd2)
                    state_next = ST_DONE;
                else
                    k_next = k_reg + 2'd1;
            end
            ST_ROOT:
            begin
                if (sqrt_done)
                begin
                    s_next[k_reg] = sqrt_root;
                    if (cmd_reg == CMD_EXCLUDE)
                        state_next = ST_APPLY;
                    else if (k_reg == 2'd2)
                    begin
                        k_next     = 2'd0;
                        state_next = ST_APPLY;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = ST_AXIS;
                    end
                end
            end
            ST_APPLY:
            begin
                if (cmd_reg == CMD_INTERSECT)
                begin
                    if (lo_reg[k_reg] >= lo_w)
                        moved_next[{k_reg, 1'b0}] = 1'b0;
                    else
                    begin
                        lo_next[k_reg] = lo_w;
                        moved_next[{k_reg, 1'b0}] = 1'b1;
                    end
                    if (up_reg[k_reg] <= hi_w)
                        moved_next[{k_reg, 1'b1}] = 1'b0;
                    else
                    begin
                        up_next[k_reg] = hi_w;
                        moved_next[{k_reg, 1'b1}] = 1'b1;
                    end
                    if (k_reg == 2'd2)
                        state_next = ST_DONE;
                    else
                        k_next = k_reg + 2'd1;
                end
                else
                begin
                    if ((pt_reg[k_reg] == lo_reg[k_reg]) && (up_reg[k_reg] <= hi_w))
                    begin
                        if (up_reg[k_reg] <= lo_w)
                            moved_next[{k_reg, 1'b1}] = 1'b0;
                        else
                        begin
                            u1_w = lo_w;
                            moved_next[{k_reg, 1'b1}] = 1'b1;
                        end
                    end
                    up_next[k_reg] = u1_w;
                    if ((pt_reg[k_reg] == u1_w) && (lo_reg[k_reg] >= lo_w))
                    begin
                        if (lo_reg[k_reg] >= hi_w)
                            moved_next[{k_reg, 1'b0}] = 1'b0;
                        else
                        begin
                            lo_next[k_reg] = hi_w;
                            moved_next[{k_reg, 1'b0}] = 1'b1;
                        end
                    end
                    if (k_reg == 2'd2)
                        state_next = ST_DONE;
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = ST_AXIS;
                    end
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_next                = rsp_reg;
        rsp_valid_next          = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
        if (rsp_load)
        begin
            rsp_valid_next         = 1'b1;
            rsp_next.lower_x       = lo_reg[0];
            rsp_next.upper_x       = up_reg[0];
            rsp_next.lower_y       = lo_reg[1];
            rsp_next.upper_y       = up_reg[1];
            rsp_next.lower_z       = lo_reg[2];
            rsp_next.upper_z       = up_reg[2];
            rsp_next.moved_flags   = moved_reg;
            rsp_next.box_empty     = empty_w;
            rsp_next.sphere_misses = miss_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= CMD_RESET;
            j_reg         <= 2'd0;
            k_reg         <= 2'd0;
            miss_reg      <= 1'b0;
            moved_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            for (int k = 0; k < DIMS; k++)
            begin
                lo_reg[k] <= CMIN;
                up_reg[k] <= CMAX;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            miss_reg      <= miss_next;
            moved_reg     <= moved_next;
            rsp_valid_reg <= rsp_valid_next;
            lo_reg        <= lo_next;
            up_reg        <= up_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg     <= c_next;
        r_reg     <= r_next;
        pt_reg    <= pt_next;
        diff_reg  <= diff_next;
        sq_reg    <= sq_next;
        r2_reg    <= r2_next;
        total_reg <= total_next;
        base_reg  <= base_next;
        s_reg     <= s_next;
        rsp_reg   <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_SAME(a_mul_in_sq, mul_done, state_reg == ST_SQ, "square finished outside square phase")
    `ASSERT_SAME(a_root_in_root, sqrt_done, state_reg == ST_ROOT, "root finished outside root phase")
    `ASSERT_NEXT(a_done_loads, state_reg == ST_DONE && !(rsp_valid && rsp_stall), rsp_valid && state_reg == ST_IDLE, "finished item not loaded")
endmodule

// File: tb/sv/tb_top.sv
// testbench top for the box/sphere clip block: predictor, driver, monitor and stimulus
module tb_top;
    import bsc_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    box_sphere_clip_3d u_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    localparam int WATCHDOG_LIMIT = 4000;

    req_t pending_items[$];
    rsp_t expected_boxes[$];
    logic signed [63:0] box_bound [6];
    logic [5:0] box_moved;
    int mismatch_count = 0;
    int req_gap = 0;
    int rsp_gap = 0;
    int quiet_cycles = 0;
    bit no_idle = 0;

    function automatic logic [63:0] coord_dist(input logic signed [63:0] a, input logic signed [63:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic logic [127:0] dist_sq(input logic signed [63:0] a, input logic signed [63:0] b);
        logic [127:0] d;
        d = {64'd0, coord_dist(a, b)};
        return d * d;
    endfunction

    function automatic logic [63:0] floor_root(input logic [127:0] x);
        logic [63:0] res;
        logic [63:0] t;
        res = 0;
        for (int b = 52; b >= 0; b--)
        begin
            t = res | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= x)
                res = t;
        end
        return res;
    endfunction

    function automatic logic signed [63:0] clamp_code(input logic signed [63:0] v);
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        lo = CMIN;
        hi = CMAX;
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [127:0] other_axes(input logic signed [63:0] p [3],
                                                input logic signed [63:0] c [3], input int skip);
        logic [127:0] acc;
        acc = 0;
        for (int j = 0; j < 3; j++)
            if (j != skip)
                acc += dist_sq(p[j], c[j]);
        return acc;
    endfunction

    function automatic void raise_bound(input int idx, input logic signed [63:0] v);
        if (box_bound[idx] >= v)
            box_moved[idx] = 1'b0;
        else
        begin
            box_bound[idx] = v;
            box_moved[idx] = 1'b1;
        end
    endfunction

    function automatic void lower_bound(input int idx, input logic signed [63:0] v);
        if (box_bound[idx] <= v)
            box_moved[idx] = 1'b0;
        else
        begin
            box_bound[idx] = v;
            box_moved[idx] = 1'b1;
        end
    endfunction

    function automatic void unbounded_box();
        for (int k = 0; k < 3; k++)
        begin
            box_bound[2*k] = CMIN;
            box_bound[2*k+1] = CMAX;
        end
        box_moved = '0;
    endfunction

    function automatic rsp_t clip_box(input req_t it);
        logic signed [63:0] c [3];
        logic signed [63:0] p [3];
        logic [63:0] s [3];
        logic [127:0] r2;
        logic [127:0] o;
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        logic signed [63:0] rr;
        bit bad;
        rsp_t res;
        c[0] = it.center_x;
        c[1] = it.center_y;
        c[2] = it.center_z;
        rr = {33'd0, it.radius};
        r2 = {64'd0, rr} * {64'd0, rr};
        bad = 0;
        res = '0;
        for (int k = 0; k < 3; k++)
        begin
            p[k] = c[k];
            if (p[k] <= box_bound[2*k])
                p[k] = box_bound[2*k];
            if (p[k] >= box_bound[2*k+1])
                p[k] = box_bound[2*k+1];
        end
        case (it.command)
            CMD_RESET: unbounded_box();
            CMD_EMPTY:
                for (int k = 0; k < 6; k++)
                    box_bound[k] = 0;
            CMD_MISS:
                if (r2 <= other_axes(p, c, -1))
                begin
                    res.sphere_misses = 1'b1;
                    box_moved = '0;
                end
            CMD_INTERSECT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (!bad)
                    begin
                        o = other_axes(p, c, k);
                        if (r2 <= o)
                            bad = 1;
                        else
                            s[k] = floor_root(r2 - o);
                    end
                end
                if (bad)
                begin
                    box_bound[0] = box_bound[1];
                    box_moved = '0;
                end
                else
                    for (int k = 0; k < 3; k++)
                    begin
                        raise_bound(2*k, clamp_code(c[k] - $signed(s[k])));
                        lower_bound(2*k+1, clamp_code(c[k] + $signed(s[k])));
                    end
            end
            CMD_EXCLUDE:
            begin
                box_moved = '0;
                for (int k = 0; k < 3; k++)
                    p[k] = (coord_dist(c[k], box_bound[2*k+1]) >= coord_dist(c[k], box_bound[2*k]))
                           ? box_bound[2*k+1] : box_bound[2*k];
                for (int k = 0; k < 3; k++)
                begin
                    o = other_axes(p, c, k);
                    if (!(r2 <= o))
                    begin
                        s[k] = floor_root(r2 - o);
                        hi = clamp_code(c[k] + $signed(s[k]));
                        lo = clamp_code(c[k] - $signed(s[k]));
                        if (p[k] == box_bound[2*k] && box_bound[2*k+1] <= hi)
                            lower_bound(2*k+1, lo);
                        if (p[k] == box_bound[2*k+1] && box_bound[2*k] >= lo)
                            raise_bound(2*k, hi);
                    end
                end
            end
            CMD_CUBE:
                for (int k = 0; k < 3; k++)
                begin
                    box_bound[2*k] = clamp_code(c[k] - rr);
                    box_bound[2*k+1] = clamp_code(c[k] + rr);
                end
            default: ;
        endcase
        for (int k = 0; k < 3; k++)
            if (box_bound[2*k] >= box_bound[2*k+1])
                res.box_empty = 1'b1;
        res.lower_x = box_bound[0][31:0];
        res.upper_x = box_bound[1][31:0];
        res.lower_y = box_bound[2][31:0];
        res.upper_y = box_bound[3][31:0];
        res.lower_z = box_bound[4][31:0];
        res.upper_z = box_bound[5][31:0];
        res.moved_flags = box_moved;
        return res;
    endfunction

    function automatic void note_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endfunction

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: return $urandom_range(0, 1) ? CMIN : CMAX;
            default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    function automatic radius_t pick_radius();
        case ($urandom_range(0, 9))
            0: return radius_t'($urandom);
            1: return $urandom_range(0, 1) ? '0 : '1;
            default: return radius_t'($urandom_range(0, 32'h0018_0000));
        endcase
    endfunction

    function automatic req_t make_item(input cmd_t cmd, input coord_t x, input coord_t y,
                                       input coord_t z, input radius_t r);
        req_t it;
        it.command = cmd;
        it.center_x = x;
        it.center_y = y;
        it.center_z = z;
        it.radius = r;
        return it;
    endfunction

    function automatic req_t random_item(input cmd_t cmd);
        return make_item(cmd, pick_coord(), pick_coord(), pick_coord(), pick_radius());
    endfunction

    initial
    begin
        forever #10 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else
        begin
            if (req_valid && !req_stall)
                expected_boxes.push_back(clip_box(req));
            if (!req_valid || !req_stall)
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    req <= pending_items.pop_front();
                    req_valid <= 1'b1;
                    if (!no_idle && $urandom_range(0, 5) == 0)
                        req_gap = $urandom_range(1, 12);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // monitor, receiver stalls and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_boxes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected item: %h", rsp);
                end
                else
                begin
                    rsp_t e;
                    e = expected_boxes.pop_front();
                    note_field("lower_x", e.lower_x, rsp.lower_x);
                    note_field("upper_x", e.upper_x, rsp.upper_x);
                    note_field("lower_y", e.lower_y, rsp.lower_y);
                    note_field("upper_y", e.upper_y, rsp.upper_y);
                    note_field("lower_z", e.lower_z, rsp.lower_z);
                    note_field("upper_z", e.upper_z, rsp.upper_z);
                    note_field("moved_flags", e.moved_flags, rsp.moved_flags);
                    note_field("box_empty", e.box_empty, rsp.box_empty);
                    note_field("sphere_misses", e.sphere_misses, rsp.sphere_misses);
                end
            end
            if (no_idle)
                rsp_stall <= 1'b0;
            else if (rsp_gap > 0)
            begin
                rsp_gap--;
                rsp_stall <= 1'b1;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                rsp_gap = $urandom_range(0, 11);
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
            if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
                quiet_cycles = 0;
            else if (++quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        unbounded_box();
        pending_items.push_back(make_item(CMD_MISS, 0, 0, 0, '0));
        pending_items.push_back(make_item(CMD_MISS, 0, 0, 0, 31'h0001_0000));
        pending_items.push_back(make_item(CMD_INTERSECT, 0, 0, 0, '1));
        pending_items.push_back(make_item(CMD_RESET, CMAX, CMIN, 0, '1));
        pending_items.push_back(make_item(CMD_EXCLUDE, 0, 0, 0, '1));
        pending_items.push_back(make_item(CMD_CUBE, 0, 0, 0, 31'h0004_0000));
        pending_items.push_back(make_item(CMD_INTERSECT, 32'sh0002_0000, 0, 0, 31'h0003_0000));
        pending_items.push_back(make_item(CMD_EXCLUDE, 32'sh0005_0000, 0, 0, 31'h0002_8000));
        pending_items.push_back(make_item(CMD_MISS, 32'sh0100_0000, 0, 0, 31'h0001_0000));
        pending_items.push_back(make_item(CMD_INTERSECT, 32'sh0100_0000, 0, 0, 31'h0001_0000));
        pending_items.push_back(make_item(CMD_CUBE, CMAX, CMIN, CMAX, '1));
        pending_items.push_back(make_item(CMD_INTERSECT, CMIN, CMAX, CMIN, '1));
        pending_items.push_back(make_item(CMD_CUBE, CMIN, CMAX, 0, '0));
        pending_items.push_back(make_item(CMD_INTERSECT, 0, 0, 0, '0));
        pending_items.push_back(make_item(CMD_EMPTY, 0, 0, 0, '0));
        pending_items.push_back(make_item(CMD_MISS, 0, 0, 0, 31'h0000_0001));
        pending_items.push_back(make_item(CMD_EXCLUDE, 0, 0, 0, 31'h0001_0000));
        pending_items.push_back(make_item(cmd_t'(6), CMAX, CMAX, CMAX, '1));
        pending_items.push_back(make_item(cmd_t'(7), CMIN, CMIN, CMIN, '1));
        pending_items.push_back(make_item(CMD_RESET, 0, 0, 0, '0));
        pending_items.push_back(make_item(CMD_EXCLUDE, CMAX, CMIN, CMAX, 31'h0100_0000));
        n = pending_items.size();
        while (n < 1400)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                pending_items.push_back(random_item(CMD_CUBE));
                n++;
                repeat ($urandom_range(2, 5))
                begin
                    case ($urandom_range(0, 2))
                        0: pending_items.push_back(random_item(CMD_INTERSECT));
                        1: pending_items.push_back(random_item(CMD_EXCLUDE));
                        default: pending_items.push_back(random_item(CMD_MISS));
                    endcase
                    n++;
                end
            end
            else
            begin
                pending_items.push_back(random_item(cmd_t'($urandom_range(0, 7))));
                n++;
            end
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_items.size() < 150);
        no_idle = 1;
        wait (pending_items.size() == 0 && !req_valid && expected_boxes.size() == 0);
        repeat (300) @(posedge clk);
        if (mismatch_count == 0 && expected_boxes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
